### rtl/string_prefix_to_rank_number_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the string rank unit
// Each macro expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef STRING_PREFIX_TO_RANK_NUMBER_UNIT_DEFINES_SVH
`define STRING_PREFIX_TO_RANK_NUMBER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SPRN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprn: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define SPRN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprn: next-cycle check failed");

`endif

### rtl/sprn_pkg.sv
// ----------------------------------------------------------------------------
// sprn_pkg
// Widths, register indexes and shared types of the string rank unit.
// ----------------------------------------------------------------------------
package sprn_pkg;

    // Number of characters carried per transaction (one lane each)
    localparam int MAX_PREFIX = 9;

    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 8;
    localparam int RANK_W     = 64;
    localparam int COUNT_W    = 9;
    localparam int PLEN_W     = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam int IN_DATA_W  = LEN_W + MAX_PREFIX * CHAR_W;
    localparam int STEP_W     = $clog2(MAX_PREFIX + 1);
    localparam int EXTRA_W    = PLEN_W + 1;
    localparam int GRP_SIZE   = 3;
    localparam int NUM_GRP    = (MAX_PREFIX + GRP_SIZE - 1) / GRP_SIZE;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_CHAR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHAR_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PREFIX_LEN = 2'd2;

    // Register reset values
    localparam logic [CHAR_W-1:0]  FIRST_CHAR_RST = 8'd32;
    localparam logic [COUNT_W-1:0] CHAR_COUNT_RST = 9'd95;
    localparam logic [PLEN_W-1:0]  PREFIX_LEN_RST = 4'd9;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic [RANK_W-1:0] term;
        logic              bad;
    } lane_out_t;

endpackage

### rtl/sprn_base_gen.sv
// ----------------------------------------------------------------------------
// sprn_base_gen
// Builds the positional weights B(1..MAX_PREFIX) one step per cycle with a
// shared multiplier and drops each into the lane that uses it.
// ----------------------------------------------------------------------------
module sprn_base_gen
    import sprn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COUNT_W-1:0] char_count,
    input  logic [PLEN_W-1:0]  plen,
    output logic               busy,
    output logic [RANK_W-1:0]  lane_base [MAX_PREFIX]
);

    logic                      busy_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [RANK_W-1:0]         acc_reg;
    logic [RANK_W-1:0]         lane_base_reg [MAX_PREFIX];
    logic [RANK_W+COUNT_W-1:0] acc_prod;
    logic [RANK_W-1:0]         acc_next;

    // B(m+1) = B(m) * k + 1, wrapping
    assign acc_prod = (RANK_W+COUNT_W)'(acc_reg) * (RANK_W+COUNT_W)'(char_count);
    assign acc_next = acc_prod[RANK_W-1:0] + RANK_W'(1);

    // Step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(1);
            acc_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(1);
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MAX_PREFIX))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Lane i takes B(plen - i)
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PREFIX; i++)
        begin
            if (busy_reg && !start &&
                (EXTRA_W'(step_reg) + EXTRA_W'(i) == EXTRA_W'(plen)))
            begin
                lane_base_reg[i] <= acc_next;
            end
        end
    end

    assign busy      = busy_reg;
    assign lane_base = lane_base_reg;

`include "string_prefix_to_rank_number_unit_defines.svh"

    `SPRN_ASSERT_NEXT(base_gen_ends, clk, rst_n, busy_reg && !start && (step_reg == STEP_W'(MAX_PREFIX)) && !$past(start), !busy_reg || start)

endmodule

### rtl/sprn_lane.sv
// ----------------------------------------------------------------------------
// sprn_lane
// One character position: offset from the first code, range check and the
// weighted term (offset times B), registered.
// ----------------------------------------------------------------------------
module sprn_lane
    import sprn_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic               used,
    input  logic [CHAR_W-1:0]  ch,
    input  logic [CHAR_W-1:0]  first_char,
    input  logic [COUNT_W-1:0] char_count,
    input  logic [RANK_W-1:0]  base,
    output lane_out_t          lane_out
);

    logic [CHAR_W:0]          off;
    logic                     neg;
    logic [CHAR_W-1:0]        mag;
    logic [RANK_W+CHAR_W-1:0] prod_full;
    logic [RANK_W-1:0]        prod;
    logic [RANK_W-1:0]        term;
    logic                     bad;
    lane_out_t                lane_out_reg;

    // Signed offset, magnitude at most 255
    assign off = {1'b0, ch} - {1'b0, first_char};
    assign neg = off[CHAR_W];
    assign mag = neg ? CHAR_W'(~off + (CHAR_W+1)'(1)) : off[CHAR_W-1:0];

    // Weighted term modulo 2^64, sign restored after the multiply
    assign prod_full = (RANK_W+CHAR_W)'(base) * (RANK_W+CHAR_W)'(mag);
    assign prod      = prod_full[RANK_W-1:0];
    assign term      = neg ? (~prod + RANK_W'(1)) : prod;

    // A negative offset wraps to a huge value, always outside the set
    assign bad = used && (neg || (COUNT_W'(off[CHAR_W-1:0]) >= char_count));

    // Hold the lane result for the merge stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_out_reg.term <= used ? term : '0;
            lane_out_reg.bad  <= bad;
        end
    end

    assign lane_out = lane_out_reg;

endmodule

### rtl/sprn_merge.sv
// ----------------------------------------------------------------------------
// sprn_merge
// Adds the lane terms in a two-level registered tree, adds the count of
// used characters and the overlength mark, and drives the output register.
// ----------------------------------------------------------------------------
module sprn_merge
    import sprn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lane_out_t          lanes [MAX_PREFIX],
    input  logic [EXTRA_W-1:0] extra,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [RANK_W-1:0]  rank,
    output logic               bad_char
);

    logic               grp_valid_reg;
    logic [RANK_W-1:0]  grp_sum_reg [NUM_GRP];
    logic [RANK_W-1:0]  grp_sum_next [NUM_GRP];
    logic               grp_bad_reg;
    logic               grp_bad_next;
    logic [EXTRA_W-1:0] grp_extra_reg;
    logic               out_valid_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;
    logic               bad_reg;
    logic               out_ready;
    logic               grp_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign grp_ready = !grp_valid_reg || out_ready;
    assign in_ready  = grp_ready;

    // First level: partial sums over groups of lanes
    always_comb
    begin
        grp_bad_next = 1'b0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_sum_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < MAX_PREFIX)
                begin
                    grp_sum_next[g] = grp_sum_next[g] + lanes[g * GRP_SIZE + j].term;
                    grp_bad_next    = grp_bad_next | lanes[g * GRP_SIZE + j].bad;
                end
            end
        end
    end

    // Second level: total plus one per used character and the overlength mark
    always_comb
    begin
        rank_next = RANK_W'(grp_extra_reg);
        for (int g = 0; g < NUM_GRP; g++)
        begin
            rank_next = rank_next + grp_sum_reg[g];
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (grp_ready)
            begin
                grp_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= grp_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (grp_ready)
        begin
            grp_sum_reg   <= grp_sum_next;
            grp_bad_reg   <= grp_bad_next;
            grp_extra_reg <= extra;
        end
        if (out_ready)
        begin
            rank_reg <= rank_next;
            bad_reg  <= grp_bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign rank     = rank_reg;
    assign bad_char = bad_reg;

`include "string_prefix_to_rank_number_unit_defines.svh"

    `SPRN_ASSERT_NEXT(merge_takes_item, clk, rst_n, in_valid && in_ready, grp_valid_reg)

endmodule

### rtl/string_prefix_to_rank_number_unit.sv
// ----------------------------------------------------------------------------
// string_prefix_to_rank_number_unit: order-preserving rank of a string prefix
// An input transaction passes through the lane, group-sum and output
// registers; one transaction/cycle unless held by m_tready or a rebuild.
// Weight table is rebuilt by one shared multiplier after reset and after
// every register write; s_tready is low meanwhile.
// ----------------------------------------------------------------------------
module string_prefix_to_rank_number_unit
    import sprn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // length, char_0 .. char_8
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [RANK_W-1:0]     m_tdata,   // rank
    output logic [0:0]            m_tuser    // bad_char
);

    logic [CHAR_W-1:0]  first_char_reg;
    logic [COUNT_W-1:0] char_count_reg;
    logic [PLEN_W-1:0]  prefix_length_reg;
    logic [PLEN_W-1:0]  lp_eff;
    logic               table_busy;
    logic [RANK_W-1:0]  lane_base [MAX_PREFIX];
    lane_out_t          lane_res [MAX_PREFIX];
    logic [LEN_W-1:0]   len;
    logic [PLEN_W-1:0]  used_n;
    logic [EXTRA_W-1:0] extra_next;
    logic [EXTRA_W-1:0] extra_reg;
    logic               lane_valid_reg;
    logic               lane_ready;
    logic               merge_ready;
    logic               bad_bit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_char_reg    <= FIRST_CHAR_RST;
            char_count_reg    <= CHAR_COUNT_RST;
            prefix_length_reg <= PREFIX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FIRST_CHAR: first_char_reg    <= cfg_wdata[CHAR_W-1:0];
                CFG_CHAR_COUNT: char_count_reg    <= cfg_wdata[COUNT_W-1:0];
                CFG_PREFIX_LEN: prefix_length_reg <= cfg_wdata[PLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp prefix length to 1 .. MAX_PREFIX
    always_comb
    begin
        if (prefix_length_reg == '0)
        begin
            lp_eff = PLEN_W'(1);
        end
        else if (prefix_length_reg > PLEN_W'(MAX_PREFIX))
        begin
            lp_eff = PLEN_W'(MAX_PREFIX);
        end
        else
        begin
            lp_eff = prefix_length_reg;
        end
    end

    // Weight table
    sprn_base_gen u_base_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_we),
        .char_count (char_count_reg),
        .plen       (lp_eff),
        .busy       (table_busy),
        .lane_base  (lane_base)
    );

    // Used characters and the constant part of the rank
    assign len        = s_tdata[LEN_W-1:0];
    assign used_n     = (len < LEN_W'(lp_eff)) ? len[PLEN_W-1:0] : lp_eff;
    assign extra_next = EXTRA_W'(used_n) + EXTRA_W'(len > LEN_W'(lp_eff));

    assign lane_ready = !lane_valid_reg || merge_ready;
    assign s_tready   = lane_ready && !table_busy;

    // Lanes, one per character position
    for (genvar i = 0; i < MAX_PREFIX; i++)
    begin : g_lane
        sprn_lane u_lane (
            .clk        (clk),
            .load       (lane_ready),
            .used       (PLEN_W'(i) < used_n),
            .ch         (s_tdata[LEN_W + i * CHAR_W +: CHAR_W]),
            .first_char (first_char_reg),
            .char_count (char_count_reg),
            .base       (lane_base[i]),
            .lane_out   (lane_res[i])
        );
    end

    // Lane stage valid and side data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (lane_ready)
        begin
            lane_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ready)
        begin
            extra_reg <= extra_next;
        end
    end

    // Merge lanes and drive the output
    sprn_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lane_valid_reg),
        .in_ready (merge_ready),
        .lanes    (lane_res),
        .extra    (extra_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .rank     (m_tdata),
        .bad_char (bad_bit)
    );

    assign m_tuser = bad_bit;

`include "string_prefix_to_rank_number_unit_defines.svh"

    `SPRN_ASSERT_IMPL(busy_blocks_input, clk, rst_n, table_busy, !s_tready)
    `SPRN_ASSERT_NEXT(cfg_write_stalls_input, clk, rst_n, cfg_we, !s_tready)

endmodule
